FILE: hw/rtl/bab_pkg.sv
// ----------------------------------------------------------------------------
// bab_pkg: shared constants and types for the glyph blitter
// Frame and font store geometry, command codes and the merge unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package bab_pkg;

	// Frame geometry
	localparam int ROW_BYTES   = 8;
	localparam int FRAME_ROWS  = 32;
	localparam int FRAME_SIZE  = ROW_BYTES * FRAME_ROWS;
	localparam int FA_W        = $clog2(FRAME_SIZE);

	// Font geometry
	localparam int GLYPH_COUNT  = 128;
	localparam int SMALL_ROWS   = 7;
	localparam int MEDIUM_ROWS  = 10;
	localparam int LARGE_ROWS   = 16;
	localparam int SMALL_DEPTH  = GLYPH_COUNT * SMALL_ROWS;
	localparam int MEDIUM_DEPTH = GLYPH_COUNT * MEDIUM_ROWS;
	localparam int LARGE_DEPTH  = GLYPH_COUNT * LARGE_ROWS;
	localparam int SMALL_AW     = $clog2(SMALL_DEPTH);
	localparam int MEDIUM_AW    = $clog2(MEDIUM_DEPTH);
	localparam int LARGE_AW     = $clog2(LARGE_DEPTH);

	// Command codes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_DRAW = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [1:0] SIZE_SMALL  = 2'd0;
	localparam logic [1:0] SIZE_MEDIUM = 2'd1;
	localparam logic [1:0] SIZE_LARGE  = 2'd2;
	localparam logic [1:0] SIZE_NONE   = 2'd3;

	// Control of the shift and merge unit
	typedef struct packed {
		logic [2:0] shift;  // pixel offset within the first byte
		logic [1:0] slot;   // frame byte of the row: 0 first, 2 at most
		logic       wide;   // two glyph bytes per row
	} merge_ctrl_t;

	// Glyph code lies within the font
	function automatic logic code_ok(input logic [6:0] code);
		code_ok = (32'(code) < GLYPH_COUNT);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bit_aligned_glyph_blitter.sv
// ----------------------------------------------------------------------------
// bit_aligned_glyph_blitter: 1 bpp frame store with bit-aligned glyph drawing
// Loads font bytes, draws 8x7, 8x10 and 16x16 glyphs at any pixel, reads
// frame bytes.
//
//   channel   handshake          payload
//   request   start / busy       mode glyph_size x_pos y_pos glyph_code
//                                font_byte_index font_data
//   result    done (1 cycle)     read_data
//
// A font load is taken in the accept cycle and leaves busy low. A frame read
// steps through ST_RD and ST_RD_OUT and then shows done. A draw holds busy
// while it walks the glyph rows; in each row it reads and writes back merged,
// one byte a cycle, the frame bytes that the row touches (1 to 3).
// After reset a clearing pass zeroes the frame store with busy high.
// done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_aligned_glyph_blitter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [1:0] glyph_size,
	input  wire logic [5:0] x_pos,
	input  wire logic [4:0] y_pos,
	input  wire logic [6:0] glyph_code,
	input  wire logic [4:0] font_byte_index,
	input  wire logic [7:0] font_data,
	output logic            done,
	output logic      [7:0] read_data
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_RD_OUT,
		ST_FETCH,
		ST_BYTES
	} state_t;

	state_t                  state_q;
	logic [bab_pkg::FA_W-1:0] clr_q;
	logic [1:0]              size_q;
	logic [5:0]              x_q;
	logic [4:0]              y_q;
	logic [6:0]              code_q;
	logic [3:0]              r_q;
	logic [1:0]              s_q;
	logic                    done_q;
	logic [7:0]              read_data_q;

	logic accept;
	logic is_large;
	logic [2:0] j_w;
	logic [2:0] k_w;
	logic [1:0] nslots;
	logic [3:0] last_row;
	logic [5:0] row_w;
	logic [3:0] col_rd;
	logic [3:0] col_wr;
	logic       row_ok;
	logic       rd_ok;

	// Frame RAM ports
	logic                     fr_we;
	logic [bab_pkg::FA_W-1:0] fr_waddr;
	logic [7:0]               fr_wdata;
	logic                     fr_re;
	logic [bab_pkg::FA_W-1:0] fr_raddr;
	logic [7:0]               fr_rdata;

	// Font RAM ports
	logic                         load_acc;
	logic                         font_re;
	logic [3:0]                   font_row;
	logic                         sm_we;
	logic                         md_we;
	logic                         lo_we;
	logic                         hi_we;
	logic [bab_pkg::SMALL_AW-1:0]  sm_waddr;
	logic [bab_pkg::SMALL_AW-1:0]  sm_raddr;
	logic [bab_pkg::MEDIUM_AW-1:0] md_waddr;
	logic [bab_pkg::MEDIUM_AW-1:0] md_raddr;
	logic [bab_pkg::LARGE_AW-1:0]  lg_waddr;
	logic [bab_pkg::LARGE_AW-1:0]  lg_raddr;
	logic [7:0]                   sm_rdata;
	logic [7:0]                   md_rdata;
	logic [7:0]                   lo_rdata;
	logic [7:0]                   hi_rdata;
	logic [15:0]                  glyph_w;

	bab_pkg::merge_ctrl_t mctrl;
	logic [7:0]           merged;

	function automatic logic [bab_pkg::FA_W-1:0] frame_addr(
		input logic [5:0] row,
		input logic [3:0] col
	);
		frame_addr = bab_pkg::FA_W'(32'(row) * bab_pkg::ROW_BYTES + 32'(col));
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done      = done_q;
	assign read_data = read_data_q;

	// Decode the held request
	assign is_large = (size_q == bab_pkg::SIZE_LARGE);
	assign j_w    = x_q[5:3];
	assign k_w    = x_q[2:0];
	assign nslots = (is_large ? 2'd2 : 2'd1) + {1'b0, (k_w != 3'd0)};
	always_comb begin
		unique case (size_q)
			bab_pkg::SIZE_SMALL:  last_row = 4'(bab_pkg::SMALL_ROWS - 1);
			bab_pkg::SIZE_MEDIUM: last_row = 4'(bab_pkg::MEDIUM_ROWS - 1);
			default:              last_row = 4'(bab_pkg::LARGE_ROWS - 1);
		endcase
	end

	// Clip the current row and the read and write columns
	assign row_w  = {1'b0, y_q} + {2'b00, r_q};
	assign col_rd = {1'b0, j_w} + {2'b00, s_q};
	assign col_wr = {1'b0, j_w} + {2'b00, s_q - 2'd1};
	assign row_ok = (32'(row_w) < bab_pkg::FRAME_ROWS);
	assign rd_ok  = (32'(y_q) < bab_pkg::FRAME_ROWS) && (32'(j_w) < bab_pkg::ROW_BYTES);

	// Drive the frame RAM by state
	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = frame_addr(row_w, col_wr);
		fr_wdata = merged;
		fr_re    = 1'b0;
		fr_raddr = frame_addr(row_w, col_rd);
		unique case (state_q)
			ST_CLEAR: begin
				fr_we    = 1'b1;
				fr_waddr = clr_q;
				fr_wdata = 8'h00;
			end
			ST_RD: begin
				fr_re    = rd_ok;
				fr_raddr = frame_addr({1'b0, y_q}, {1'b0, j_w});
			end
			ST_BYTES: begin
				fr_we = (s_q != 2'd0) && row_ok && (32'(col_wr) < bab_pkg::ROW_BYTES);
				fr_re = (s_q < nslots) && row_ok && (32'(col_rd) < bab_pkg::ROW_BYTES);
			end
			ST_IDLE, ST_RD_OUT, ST_FETCH: begin
			end
			default: begin
			end
		endcase
	end

	bab_ram #(
		.WIDTH(8),
		.DEPTH(bab_pkg::FRAME_SIZE)
	) u_frame (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_waddr),
		.wdata(fr_wdata),
		.re   (fr_re),
		.raddr(fr_raddr),
		.rdata(fr_rdata)
	);

	// Font loads go straight to the RAMs in the accept cycle
	assign load_acc = accept && (mode == bab_pkg::MODE_LOAD) &&
		(glyph_size != bab_pkg::SIZE_NONE) && bab_pkg::code_ok(glyph_code);
	assign sm_we = load_acc && (glyph_size == bab_pkg::SIZE_SMALL) &&
		(32'(font_byte_index) < bab_pkg::SMALL_ROWS);
	assign md_we = load_acc && (glyph_size == bab_pkg::SIZE_MEDIUM) &&
		(32'(font_byte_index) < bab_pkg::MEDIUM_ROWS);
	assign lo_we = load_acc && (glyph_size == bab_pkg::SIZE_LARGE) && !font_byte_index[0];
	assign hi_we = load_acc && (glyph_size == bab_pkg::SIZE_LARGE) && font_byte_index[0];
	assign sm_waddr = bab_pkg::SMALL_AW'(32'(glyph_code) * bab_pkg::SMALL_ROWS +
		32'(font_byte_index));
	assign md_waddr = bab_pkg::MEDIUM_AW'(32'(glyph_code) * bab_pkg::MEDIUM_ROWS +
		32'(font_byte_index));
	assign lg_waddr = bab_pkg::LARGE_AW'(32'(glyph_code) * bab_pkg::LARGE_ROWS +
		32'(font_byte_index[4:1]));

	// Fetch row 0 first, then prefetch the next row during the last write
	assign font_re  = (state_q == ST_FETCH) ||
		((state_q == ST_BYTES) && (s_q == nslots) && (r_q != last_row));
	assign font_row = (state_q == ST_FETCH) ? 4'd0 : r_q + 4'd1;
	assign sm_raddr = bab_pkg::SMALL_AW'(32'(code_q) * bab_pkg::SMALL_ROWS + 32'(font_row));
	assign md_raddr = bab_pkg::MEDIUM_AW'(32'(code_q) * bab_pkg::MEDIUM_ROWS + 32'(font_row));
	assign lg_raddr = bab_pkg::LARGE_AW'(32'(code_q) * bab_pkg::LARGE_ROWS + 32'(font_row));

	bab_ram #(.WIDTH(8), .DEPTH(bab_pkg::SMALL_DEPTH)) u_font_small (
		.clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(font_data),
		.re(font_re), .raddr(sm_raddr), .rdata(sm_rdata)
	);

	bab_ram #(.WIDTH(8), .DEPTH(bab_pkg::MEDIUM_DEPTH)) u_font_medium (
		.clk(clk), .we(md_we), .waddr(md_waddr), .wdata(font_data),
		.re(font_re), .raddr(md_raddr), .rdata(md_rdata)
	);

	bab_ram #(.WIDTH(8), .DEPTH(bab_pkg::LARGE_DEPTH)) u_font_large_lo (
		.clk(clk), .we(lo_we), .waddr(lg_waddr), .wdata(font_data),
		.re(font_re), .raddr(lg_raddr), .rdata(lo_rdata)
	);

	bab_ram #(.WIDTH(8), .DEPTH(bab_pkg::LARGE_DEPTH)) u_font_large_hi (
		.clk(clk), .we(hi_we), .waddr(lg_waddr), .wdata(font_data),
		.re(font_re), .raddr(lg_raddr), .rdata(hi_rdata)
	);

	// Select the glyph row of the drawn size
	always_comb begin
		unique case (size_q)
			bab_pkg::SIZE_SMALL:  glyph_w = {8'h00, sm_rdata};
			bab_pkg::SIZE_MEDIUM: glyph_w = {8'h00, md_rdata};
			default:              glyph_w = {hi_rdata, lo_rdata};
		endcase
	end

	// Merge the byte read in the previous cycle
	assign mctrl.shift = k_w;
	assign mctrl.slot  = s_q - 2'd1;
	assign mctrl.wide  = is_large;

	bab_merge u_merge (
		.glyph   (glyph_w),
		.ctrl    (mctrl),
		.old_byte(fr_rdata),
		.new_byte(merged)
	);

	// Sequencer: clearing pass, read path and row/byte walk of a draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= 2'd0;
			x_q         <= 6'd0;
			y_q         <= 5'd0;
			code_q      <= 7'd0;
			r_q         <= 4'd0;
			s_q         <= 2'd0;
			done_q      <= 1'b0;
			read_data_q <= 8'h00;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + bab_pkg::FA_W'(1);
					if (clr_q == bab_pkg::FA_W'(bab_pkg::FRAME_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						size_q <= glyph_size;
						x_q    <= x_pos;
						y_q    <= y_pos;
						code_q <= glyph_code;
						if (mode == bab_pkg::MODE_READ) begin
							state_q <= ST_RD;
						end else if ((mode == bab_pkg::MODE_DRAW) &&
								(glyph_size != bab_pkg::SIZE_NONE) &&
								bab_pkg::code_ok(glyph_code)) begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					read_data_q <= rd_ok ? fr_rdata : 8'h00;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_FETCH: begin
					r_q     <= 4'd0;
					s_q     <= 2'd0;
					state_q <= ST_BYTES;
				end
				ST_BYTES: begin
					if (s_q == nslots) begin
						s_q <= 2'd0;
						if (r_q == last_row) begin
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_q + 4'd1;
						end
					end else begin
						s_q <= s_q + 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bab_ram.sv
// ----------------------------------------------------------------------------
// bab_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bab_merge.sv
// ----------------------------------------------------------------------------
// bab_merge: shared shift and merge unit
// Shifts one glyph row by the pixel offset and merges one slot into a frame byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_merge (
	input  wire logic                 [15:0] glyph,
	input  wire bab_pkg::merge_ctrl_t        ctrl,
	input  wire logic                 [7:0]  old_byte,
	output logic                      [7:0]  new_byte
);

	logic [23:0] bits_sh;
	logic [23:0] cover_sh;
	logic [7:0]  val;
	logic [7:0]  cov_mask;

	// Shift the row and its coverage mask together
	assign bits_sh  = {8'h00, glyph} << ctrl.shift;
	assign cover_sh = {8'h00, (ctrl.wide ? 16'hffff : 16'h00ff)} << ctrl.shift;

	// Pick the byte of this slot
	always_comb begin
		unique case (ctrl.slot)
			2'd0: begin
				val      = bits_sh[7:0];
				cov_mask = cover_sh[7:0];
			end
			2'd1: begin
				val      = bits_sh[15:8];
				cov_mask = cover_sh[15:8];
			end
			2'd2: begin
				val      = bits_sh[23:16];
				cov_mask = cover_sh[23:16];
			end
			default: begin
				val      = 8'h00;
				cov_mask = 8'h00;
			end
		endcase
	end

	// Keep frame bits outside the glyph, drop those under it
	assign new_byte = (old_byte & ~cov_mask) | val;

endmodule

`default_nettype wire

FILE: hw/rtl/bab_checker.sv
// ----------------------------------------------------------------------------
// bab_checker: port-level checks for the glyph blitter
// Watches the request and result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] mode,
	input wire logic [1:0] glyph_size,
	input wire logic [6:0] glyph_code,
	input wire logic       done
);

	logic rd_acc;
	logic draw_acc;

	assign rd_acc   = start && !busy && (mode == bab_pkg::MODE_READ);
	assign draw_acc = start && !busy && (mode == bab_pkg::MODE_DRAW) &&
		(glyph_size != bab_pkg::SIZE_NONE) && bab_pkg::code_ok(glyph_code);

	// A read request returns its byte on done
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |-> ##3 done)
		else $error("read result missing");

	// Every result stems from a read request
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(rd_acc, 3))
		else $error("result without read request");

	// Results never come in adjacent cycles
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A valid draw holds the block busy
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		draw_acc |=> busy)
		else $error("draw request did not raise busy");

endmodule

bind bit_aligned_glyph_blitter bab_checker u_bab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.glyph_size(glyph_size),
	.glyph_code(glyph_code),
	.done      (done)
);

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for bit_aligned_glyph_blitter
// Sends font loads, glyph draws and frame reads over the start/busy request
// port. It tracks the frame and font stores in a local image and checks every
// read_data strobe against the byte the image predicts. Directed requests come
// first, then mixed random traffic under three sender idle rates.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int LARGE_BYTES = 2 * bab_pkg::LARGE_ROWS;
	localparam int STORE_DEPTH = bab_pkg::GLYPH_COUNT * LARGE_BYTES;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] size;
		logic [5:0] x;
		logic [4:0] y;
		logic [6:0] code;
		logic [4:0] bidx;
		logic [7:0] data;
	} blit_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] mode = '0;
	logic [1:0] glyph_size = '0;
	logic [5:0] x_pos = '0;
	logic [4:0] y_pos = '0;
	logic [6:0] glyph_code = '0;
	logic [4:0] font_byte_index = '0;
	logic [7:0] font_data = '0;
	logic       done;
	logic [7:0] read_data;

	// Local image of the block's stores
	bit [7:0]   frame_img [bab_pkg::FRAME_ROWS * bab_pkg::ROW_BYTES];
	bit [7:0]   font_img [3][STORE_DEPTH];
	bit         font_set [3][STORE_DEPTH];
	bit         glyph_listed [3][bab_pkg::GLYPH_COUNT];
	bit [8:0]   ready_glyphs [$];
	logic [7:0] expected_bytes [$];

	int sender_gap_pct = 0;
	int issued = 0;
	int fault_count = 0;
	int stall_cycles = 0;

	bit_aligned_glyph_blitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.glyph_size(glyph_size),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.glyph_code(glyph_code),
		.font_byte_index(font_byte_index),
		.font_data(font_data),
		.done(done),
		.read_data(read_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int glyph_len(input logic [1:0] size);
		case (size)
			bab_pkg::SIZE_SMALL: glyph_len = bab_pkg::SMALL_ROWS;
			bab_pkg::SIZE_MEDIUM: glyph_len = bab_pkg::MEDIUM_ROWS;
			default: glyph_len = LARGE_BYTES;
		endcase
	endfunction

	function automatic blit_req_t make_req(input logic [1:0] m, input logic [1:0] s,
			input int x, input int y, input int code, input int bidx, input int data);
		blit_req_t req;
		req.mode = m;
		req.size = s;
		req.x = 6'(x);
		req.y = 5'(y);
		req.code = 7'(code);
		req.bidx = 5'(bidx);
		req.data = 8'(data);
		return req;
	endfunction

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Merge into one frame byte; drop bytes outside the frame
	task automatic merge_frame(input int row, input int col, input bit [7:0] keep,
			input bit [7:0] val);
		int a;
		if (row >= bab_pkg::FRAME_ROWS || col >= bab_pkg::ROW_BYTES)
			return;
		a = row * bab_pkg::ROW_BYTES + col;
		frame_img[a] = (frame_img[a] & keep) | val;
	endtask

	task automatic draw_glyph(input logic [1:0] size, input int code, input int x,
			input int y);
		int j, k, r, len;
		bit [7:0] lowk, highk, b0, b1;
		j = x / 8;
		k = x % 8;
		len = glyph_len(size);
		lowk = 8'hff >> (8 - k);
		highk = 8'hff << k;
		if (size == bab_pkg::SIZE_LARGE) begin
			for (r = 0; r < bab_pkg::LARGE_ROWS; r++) begin
				b0 = font_img[size][code * len + 2 * r];
				b1 = font_img[size][code * len + 2 * r + 1];
				if (k > 0) begin
					merge_frame(y + r, j, lowk, b0 << k);
					merge_frame(y + r, j + 1, 8'h00, (b0 >> (8 - k)) | (b1 << k));
					merge_frame(y + r, j + 2, highk, b1 >> (8 - k));
				end else begin
					merge_frame(y + r, j, 8'h00, b0);
					merge_frame(y + r, j + 1, 8'h00, b1);
				end
			end
		end else begin
			for (r = 0; r < len; r++) begin
				b0 = font_img[size][code * len + r];
				if (k > 0) begin
					merge_frame(y + r, j, lowk, b0 << k);
					merge_frame(y + r, j + 1, highk, b0 >> (8 - k));
				end else begin
					merge_frame(y + r, j, 8'h00, b0);
				end
			end
		end
	endtask

	// Advance the local image by one accepted request
	task automatic track_request(input blit_req_t req);
		int len, i;
		bit full;
		if (req.mode == bab_pkg::MODE_READ) begin
			expected_bytes.push_back(frame_img[req.y * bab_pkg::ROW_BYTES + req.x / 8]);
			return;
		end
		if (req.mode == MODE_NONE || req.size == bab_pkg::SIZE_NONE ||
				!(int'(req.code) < bab_pkg::GLYPH_COUNT))
			return;
		len = glyph_len(req.size);
		if (req.mode == bab_pkg::MODE_DRAW) begin
			draw_glyph(req.size, int'(req.code), int'(req.x), int'(req.y));
			return;
		end
		if (req.bidx >= len)
			return;
		font_img[req.size][req.code * len + req.bidx] = req.data;
		font_set[req.size][req.code * len + req.bidx] = 1'b1;
		// list the glyph for drawing once every byte is known
		if (!glyph_listed[req.size][req.code]) begin
			full = 1'b1;
			for (i = 0; i < len; i++)
				if (!font_set[req.size][req.code * len + i])
					full = 1'b0;
			if (full) begin
				glyph_listed[req.size][req.code] = 1'b1;
				ready_glyphs.push_back({req.size, req.code});
			end
		end
	endtask

	// Drive one request and hold it until the block takes it
	task automatic issue(input blit_req_t req);
		int idle;
		@(negedge clk);
		if ($urandom_range(99) < sender_gap_pct) begin
			start = 1'b0;
			idle = $urandom_range(4, 1);
			repeat (idle) @(negedge clk);
		end
		mode = req.mode;
		glyph_size = req.size;
		x_pos = req.x;
		y_pos = req.y;
		glyph_code = req.code;
		font_byte_index = req.bidx;
		font_data = req.data;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_request(req);
		issued++;
	endtask

	task automatic read_byte(input int x, input int y);
		issue(make_req(bab_pkg::MODE_READ, 2'($urandom), x, y, $urandom, $urandom,
			$urandom));
	endtask

	task automatic load_glyph(input logic [1:0] size, input int code);
		int i;
		for (i = 0; i < glyph_len(size); i++)
			issue(make_req(bab_pkg::MODE_LOAD, size, $urandom, $urandom, code, i,
				($urandom_range(9) == 0) ? 255 : $urandom));
	endtask

	// Draw a listed glyph somewhere, then read back bytes it may touch
	task automatic draw_and_probe(input bit [8:0] glyph);
		int x, y, n, rows;
		x = $urandom_range(63);
		y = $urandom_range(31);
		rows = (glyph[8:7] == bab_pkg::SIZE_LARGE) ? bab_pkg::LARGE_ROWS :
			glyph_len(glyph[8:7]);
		issue(make_req(bab_pkg::MODE_DRAW, glyph[8:7], x, y, int'(glyph[6:0]), $urandom,
			$urandom));
		n = $urandom_range(4, 2);
		repeat (n)
			read_byte(((x / 8 + $urandom_range(2)) * 8 + $urandom_range(7)) % 64,
				(y + $urandom_range(rows - 1)) % 32);
	endtask

	task automatic test_cleared_frame();
		read_byte(0, 0);
		read_byte(63, 31);
		read_byte(29, 17);
	endtask

	task automatic test_ignored_requests();
		issue(make_req(MODE_NONE, bab_pkg::SIZE_SMALL, 8, 0, 1, 0, 255));
		issue(make_req(bab_pkg::MODE_LOAD, bab_pkg::SIZE_NONE, 0, 0, 1, 0, 255));
		issue(make_req(bab_pkg::MODE_DRAW, bab_pkg::SIZE_NONE, 0, 0, 1, 0, 255));
		issue(make_req(bab_pkg::MODE_LOAD, bab_pkg::SIZE_SMALL, 0, 0, 0,
			bab_pkg::SMALL_ROWS, 255));
		issue(make_req(bab_pkg::MODE_LOAD, bab_pkg::SIZE_MEDIUM, 0, 0, 0, 31, 255));
	endtask

	task automatic test_glyph_load();
		bit [7:0] pattern [bab_pkg::SMALL_ROWS] =
			'{8'hff, 8'h00, 8'h81, 8'h7e, 8'h01, 8'h80, 8'haa};
		int i;
		for (i = 0; i < bab_pkg::SMALL_ROWS; i++)
			issue(make_req(bab_pkg::MODE_LOAD, bab_pkg::SIZE_SMALL, 0, 0, 127, i,
				int'(pattern[i])));
	endtask

	task automatic test_aligned_draw();
		issue(make_req(bab_pkg::MODE_DRAW, bab_pkg::SIZE_SMALL, 0, 0, 127, 0, 0));
		read_byte(0, 0);
		read_byte(7, 6);
	endtask

	task automatic test_unaligned_merge();
		issue(make_req(bab_pkg::MODE_DRAW, bab_pkg::SIZE_SMALL, 3, 2, 127, 0, 0));
		read_byte(0, 2);
		read_byte(8, 2);
	endtask

	task automatic test_edge_clip();
		issue(make_req(bab_pkg::MODE_DRAW, bab_pkg::SIZE_SMALL, 61, 29, 127, 0, 0));
		read_byte(56, 29);
		read_byte(63, 31);
	endtask

	// Mix well-formed load-then-draw sequences with reads, stray loads and noise
	task automatic test_mixed_traffic(input int n_items);
		int target, pick;
		blit_req_t req;
		target = issued + n_items;
		while (issued < target) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				req.size = 2'($urandom_range(2));
				req.code = 7'($urandom_range(127));
				load_glyph(req.size, int'(req.code));
				draw_and_probe({req.size, req.code});
				if ($urandom_range(1))
					draw_and_probe({req.size, req.code});
			end else if (pick < 55 && ready_glyphs.size() != 0) begin
				draw_and_probe(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
			end else if (pick < 80) begin
				read_byte($urandom_range(63), $urandom_range(31));
			end else if (pick < 90) begin
				issue(make_req(bab_pkg::MODE_LOAD, 2'($urandom_range(2)), $urandom,
					$urandom, $urandom, $urandom, $urandom));
			end else begin
				req = make_req(MODE_NONE, 2'($urandom), $urandom, $urandom, $urandom,
					$urandom, $urandom);
				if ($urandom_range(1)) begin
					req.mode = $urandom_range(1) ? bab_pkg::MODE_LOAD : bab_pkg::MODE_DRAW;
					req.size = bab_pkg::SIZE_NONE;
				end
				issue(req);
			end
		end
	endtask

	// Check each strobed byte against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_bytes.size() == 0) begin
				flag_fault($sformatf("read_data %02h with no read pending", read_data));
			end else if (read_data !== expected_bytes[0]) begin
				flag_fault($sformatf("read_data expected %02h actual %02h",
					expected_bytes[0], read_data));
				void'(expected_bytes.pop_front());
			end else begin
				void'(expected_bytes.pop_front());
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		sender_gap_pct = 6;
		test_cleared_frame();
		test_ignored_requests();
		test_glyph_load();
		test_aligned_draw();
		test_unaligned_merge();
		test_edge_clip();
		test_mixed_traffic(250);
		sender_gap_pct = 50;
		test_mixed_traffic(250);
		sender_gap_pct = 0;
		test_mixed_traffic(250);

		// drain outstanding reads, then let any draw finish
		@(negedge clk);
		start = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			flag_fault($sformatf("%0d reads never returned", expected_bytes.size()));
		if (fault_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
